// File: sv/gpuf_pkg.sv
// ----------------------------------------------------------------------------
// gpuf_pkg
// Shared sizes, codes, types and helpers of the percolation union-find core.
// ----------------------------------------------------------------------------
`default_nettype none

package gpuf_pkg;

    localparam int MAX_SIDE   = 32;
    localparam int ROW_W      = $clog2(MAX_SIDE);
    localparam int SITE_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int NODE_COUNT = SITE_COUNT + 2;
    localparam int SITE_W     = $clog2(SITE_COUNT);
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int WGT_W      = $clog2(NODE_COUNT + 1);
    localparam int CFG_W      = 6;

    localparam logic [CFG_W-1:0]  SIDE_RESET  = CFG_W'(32);
    localparam logic [NODE_W-1:0] TOP_NODE    = '0;
    localparam logic [NODE_W-1:0] BOTTOM_NODE = NODE_W'(SITE_COUNT + 1);
    localparam logic [NODE_W-1:0] LAST_NODE   = NODE_W'(NODE_COUNT - 1);

    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_PROBE = 1'b1;

    // join candidates, walked in this order for an open
    localparam int CAND_W = 3;
    localparam logic [CAND_W-1:0] CAND_TOP    = 3'd0;
    localparam logic [CAND_W-1:0] CAND_BOTTOM = 3'd1;
    localparam logic [CAND_W-1:0] CAND_UP     = 3'd2;
    localparam logic [CAND_W-1:0] CAND_DOWN   = 3'd3;
    localparam logic [CAND_W-1:0] CAND_LEFT   = 3'd4;
    localparam logic [CAND_W-1:0] CAND_RIGHT  = 3'd5;
    localparam logic [CAND_W-1:0] CAND_END    = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SELF,
        S_CAND,
        S_NBR,
        S_FIND,
        S_UNI,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_JOIN_A,
        PH_JOIN_B,
        PH_TOP,
        PH_NODE,
        PH_BOTTOM
    } t_phase;

    typedef struct packed {
        logic              re;
        logic [SITE_W-1:0] raddr;
        logic              we;
        logic [SITE_W-1:0] waddr;
        logic              wdata;
    } t_map_req;

    typedef struct packed {
        logic              re;
        logic [NODE_W-1:0] raddr;
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [NODE_W-1:0] wdata;
    } t_par_req;

    typedef struct packed {
        logic              re;
        logic [NODE_W-1:0] raddr;
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [WGT_W-1:0]  wdata;
    } t_wgt_req;

    typedef struct packed {
        logic was_open;
        logic site_full;
        logic percolates_now;
        logic range_error;
    } t_result;

    function automatic logic [SITE_W-1:0] site_of(input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W-1:0] col);
        site_of = SITE_W'(32'(row) * MAX_SIDE + 32'(col));
    endfunction

    function automatic logic [NODE_W-1:0] node_of(input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W-1:0] col);
        node_of = NODE_W'(32'(row) * MAX_SIDE + 32'(col) + 1);
    endfunction

endpackage

`default_nettype wire

// File: sv/grid_percolation_union_find_core.sv
// ----------------------------------------------------------------------------
// grid_percolation_union_find_core
// Percolation grid with a weighted union-find forest held in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word: kind, row and
//   column. kind 0 opens the site, kind 1 probes it. Output channel
//   (o_out_valid / i_out_stall) returns one word per input word: was_open,
//   site_full, percolates_now, range_error.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes grid_side; it
//   is always ready. Write it only while no word is in flight.
//   After reset the block sweeps the open map, parent and weight memories,
//   one node per cycle, with o_in_stall high.
//   Work per word: an in-range probe makes three root walks (top, site,
//   bottom), an out-of-range word two; an open first walks its join
//   candidates and makes up to four joins, each two root walks. Every
//   step of a root walk is one parent memory read per cycle, and weighted
//   union bounds the depth of every tree. One word is worked on at a time.
//   The result sits in an output register; a stalled receiver holds it
//   there while the next input word is already taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_percolation_union_find_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [gpuf_pkg::CFG_W-1:0]  i_cfg_data,
    // input word
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_kind,
    input  wire logic [gpuf_pkg::ROW_W-1:0]  i_row,
    input  wire logic [gpuf_pkg::ROW_W-1:0]  i_column,
    // result word
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_was_open,
    output logic                             o_site_full,
    output logic                             o_percolates_now,
    output logic                             o_range_error
);

    logic [gpuf_pkg::CFG_W-1:0] r_side;
    logic [gpuf_pkg::CFG_W-1:0] side_eff;
    logic                       r_out_valid;
    gpuf_pkg::t_result          r_out;

    logic                       seq_idle;
    logic                       res_valid;
    logic                       res_take;
    gpuf_pkg::t_result          res;

    gpuf_pkg::t_map_req         map_req;
    gpuf_pkg::t_par_req         par_req;
    gpuf_pkg::t_wgt_req         wgt_req;
    logic                       map_rdata;
    logic [gpuf_pkg::NODE_W-1:0] par_rdata;
    logic [gpuf_pkg::WGT_W-1:0]  wgt_rdata;

    // hold grid_side; a side above the largest grid acts as the largest grid
    assign o_cfg_ready = 1'b1;
    assign side_eff = ({1'b0, r_side} > (gpuf_pkg::CFG_W + 1)'(gpuf_pkg::MAX_SIDE))
                    ? gpuf_pkg::CFG_W'(gpuf_pkg::MAX_SIDE) : r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= gpuf_pkg::SIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_side <= i_cfg_data;
        end
    end

    // take new input words only while the sequencer waits
    assign o_in_stall = ~seq_idle;

    // output register: load when empty or when the held word leaves
    assign res_take = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) r_out <= res;
    end

    assign o_out_valid      = r_out_valid;
    assign o_was_open       = r_out.was_open;
    assign o_site_full      = r_out.site_full;
    assign o_percolates_now = r_out.percolates_now;
    assign o_range_error    = r_out.range_error;

    gpuf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_side      (side_eff),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_row       (i_row),
        .i_column    (i_column),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_map_req   (map_req),
        .i_map_rdata (map_rdata),
        .o_par_req   (par_req),
        .i_par_rdata (par_rdata),
        .o_wgt_req   (wgt_req),
        .i_wgt_rdata (wgt_rdata)
    );

    // open flag per site
    gpuf_ram #(
        .WIDTH (1),
        .DEPTH (gpuf_pkg::SITE_COUNT)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_req.we),
        .i_waddr (map_req.waddr),
        .i_wdata (map_req.wdata),
        .i_re    (map_req.re),
        .i_raddr (map_req.raddr),
        .o_rdata (map_rdata)
    );

    // parent link per node
    gpuf_ram #(
        .WIDTH (gpuf_pkg::NODE_W),
        .DEPTH (gpuf_pkg::NODE_COUNT)
    ) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (par_req.we),
        .i_waddr (par_req.waddr),
        .i_wdata (par_req.wdata),
        .i_re    (par_req.re),
        .i_raddr (par_req.raddr),
        .o_rdata (par_rdata)
    );

    // tree weight per node, meaningful at roots only
    gpuf_ram #(
        .WIDTH (gpuf_pkg::WGT_W),
        .DEPTH (gpuf_pkg::NODE_COUNT)
    ) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (wgt_req.we),
        .i_waddr (wgt_req.waddr),
        .i_wdata (wgt_req.wdata),
        .i_re    (wgt_req.re),
        .i_raddr (wgt_req.raddr),
        .o_rdata (wgt_rdata)
    );

endmodule

`default_nettype wire

// File: sv/gpuf_ram.sv
// ----------------------------------------------------------------------------
// gpuf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/gpuf_seq.sv
// ----------------------------------------------------------------------------
// gpuf_seq
// Sequencer: clears the forest, walks the joins of an open and the root
// finds of the final checks through the three memories.
// ----------------------------------------------------------------------------
`default_nettype none

module gpuf_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [gpuf_pkg::CFG_W-1:0]    i_side,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_kind,
    input  wire logic [gpuf_pkg::ROW_W-1:0]    i_row,
    input  wire logic [gpuf_pkg::ROW_W-1:0]    i_column,
    output logic                               o_idle,
    output logic                               o_res_valid,
    input  wire logic                          i_res_take,
    output gpuf_pkg::t_result                  o_res,
    output gpuf_pkg::t_map_req                 o_map_req,
    input  wire logic                          i_map_rdata,
    output gpuf_pkg::t_par_req                 o_par_req,
    input  wire logic [gpuf_pkg::NODE_W-1:0]   i_par_rdata,
    output gpuf_pkg::t_wgt_req                 o_wgt_req,
    input  wire logic [gpuf_pkg::WGT_W-1:0]    i_wgt_rdata
);

    gpuf_pkg::t_state r_state, n_state;
    gpuf_pkg::t_phase r_phase;

    logic [gpuf_pkg::NODE_W-1:0] r_clr;
    logic                        r_kind;
    logic [gpuf_pkg::ROW_W-1:0]  r_row;
    logic [gpuf_pkg::ROW_W-1:0]  r_col;
    logic                        r_err;
    logic [gpuf_pkg::NODE_W-1:0] r_node;
    logic                        r_was;
    logic [gpuf_pkg::CAND_W-1:0] r_cand;
    logic [gpuf_pkg::NODE_W-1:0] r_cur;
    logic [gpuf_pkg::NODE_W-1:0] r_a;
    logic [gpuf_pkg::NODE_W-1:0] r_b;
    logic [gpuf_pkg::NODE_W-1:0] r_ra;
    logic [gpuf_pkg::NODE_W-1:0] r_rb;
    logic [gpuf_pkg::WGT_W-1:0]  r_wa;
    logic [gpuf_pkg::NODE_W-1:0] r_rt;
    logic                        r_full;
    logic                        r_perc;

    logic                        in_range;
    logic                        is_root;
    logic                        last_row;
    logic                        nbr_ok;
    logic [gpuf_pkg::ROW_W-1:0]  nbr_row;
    logic [gpuf_pkg::ROW_W-1:0]  nbr_col;
    logic [gpuf_pkg::WGT_W-1:0]  wsum;

    assign in_range = (gpuf_pkg::CFG_W'(i_row) < i_side)
                   && (gpuf_pkg::CFG_W'(i_column) < i_side);
    assign is_root  = (i_par_rdata == r_cur);
    assign last_row = ((gpuf_pkg::CFG_W'(r_row) + gpuf_pkg::CFG_W'(1)) == i_side);
    assign wsum     = r_wa + i_wgt_rdata;

    // neighbor of the candidate under test
    always_comb begin
        nbr_row = r_row;
        nbr_col = r_col;
        nbr_ok  = 1'b0;
        case (r_cand)
            gpuf_pkg::CAND_UP: begin
                nbr_row = r_row - gpuf_pkg::ROW_W'(1);
                nbr_ok  = (r_row != '0);
            end
            gpuf_pkg::CAND_DOWN: begin
                nbr_row = r_row + gpuf_pkg::ROW_W'(1);
                nbr_ok  = ((gpuf_pkg::CFG_W'(r_row) + gpuf_pkg::CFG_W'(1)) < i_side);
            end
            gpuf_pkg::CAND_LEFT: begin
                nbr_col = r_col - gpuf_pkg::ROW_W'(1);
                nbr_ok  = (r_col != '0);
            end
            gpuf_pkg::CAND_RIGHT: begin
                nbr_col = r_col + gpuf_pkg::ROW_W'(1);
                nbr_ok  = ((gpuf_pkg::CFG_W'(r_col) + gpuf_pkg::CFG_W'(1)) < i_side);
            end
            default: begin
                nbr_ok = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gpuf_pkg::S_CLEAR: begin
                if (r_clr == gpuf_pkg::LAST_NODE) n_state = gpuf_pkg::S_IDLE;
            end
            gpuf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = in_range ? gpuf_pkg::S_SELF : gpuf_pkg::S_FIND;
            end
            gpuf_pkg::S_SELF: begin
                n_state = (r_kind == gpuf_pkg::KIND_PROBE) ? gpuf_pkg::S_FIND
                                                            : gpuf_pkg::S_CAND;
            end
            gpuf_pkg::S_CAND: begin
                case (r_cand)
                    gpuf_pkg::CAND_TOP: begin
                        if (r_row == '0) n_state = gpuf_pkg::S_FIND;
                    end
                    gpuf_pkg::CAND_BOTTOM: begin
                        if (last_row) n_state = gpuf_pkg::S_FIND;
                    end
                    gpuf_pkg::CAND_END: begin
                        n_state = gpuf_pkg::S_FIND;
                    end
                    default: begin
                        if (nbr_ok) n_state = gpuf_pkg::S_NBR;
                    end
                endcase
            end
            gpuf_pkg::S_NBR: begin
                n_state = i_map_rdata ? gpuf_pkg::S_FIND : gpuf_pkg::S_CAND;
            end
            gpuf_pkg::S_FIND: begin
                if (is_root) begin
                    case (r_phase)
                        gpuf_pkg::PH_JOIN_B: begin
                            n_state = (r_cur == r_ra) ? gpuf_pkg::S_CAND : gpuf_pkg::S_UNI;
                        end
                        gpuf_pkg::PH_BOTTOM: begin
                            n_state = gpuf_pkg::S_DONE;
                        end
                        default: begin
                            n_state = gpuf_pkg::S_FIND;
                        end
                    endcase
                end
            end
            gpuf_pkg::S_UNI: begin
                n_state = gpuf_pkg::S_CAND;
            end
            gpuf_pkg::S_DONE: begin
                if (i_res_take) n_state = gpuf_pkg::S_IDLE;
            end
            default: begin
                n_state = gpuf_pkg::S_CLEAR;
            end
        endcase
    end

    // memory requests and handshake outputs
    always_comb begin
        o_map_req   = '0;
        o_par_req   = '0;
        o_wgt_req   = '0;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            gpuf_pkg::S_CLEAR: begin
                o_map_req.we    = 1'b1;
                o_map_req.waddr = r_clr[gpuf_pkg::SITE_W-1:0];
                o_map_req.wdata = 1'b0;
                o_par_req.we    = 1'b1;
                o_par_req.waddr = r_clr;
                o_par_req.wdata = r_clr;
                o_wgt_req.we    = 1'b1;
                o_wgt_req.waddr = r_clr;
                o_wgt_req.wdata = gpuf_pkg::WGT_W'(1);
            end
            gpuf_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_valid) begin
                    if (in_range) begin
                        o_map_req.re    = 1'b1;
                        o_map_req.raddr = gpuf_pkg::site_of(i_row, i_column);
                    end else begin
                        o_par_req.re    = 1'b1;
                        o_par_req.raddr = gpuf_pkg::TOP_NODE;
                    end
                end
            end
            gpuf_pkg::S_SELF: begin
                if (r_kind == gpuf_pkg::KIND_PROBE) begin
                    o_par_req.re    = 1'b1;
                    o_par_req.raddr = gpuf_pkg::TOP_NODE;
                end else begin
                    o_map_req.we    = 1'b1;
                    o_map_req.waddr = gpuf_pkg::site_of(r_row, r_col);
                    o_map_req.wdata = 1'b1;
                end
            end
            gpuf_pkg::S_CAND: begin
                case (r_cand)
                    gpuf_pkg::CAND_TOP: begin
                        o_par_req.re    = (r_row == '0);
                        o_par_req.raddr = gpuf_pkg::TOP_NODE;
                    end
                    gpuf_pkg::CAND_BOTTOM: begin
                        o_par_req.re    = last_row;
                        o_par_req.raddr = gpuf_pkg::BOTTOM_NODE;
                    end
                    gpuf_pkg::CAND_END: begin
                        o_par_req.re    = 1'b1;
                        o_par_req.raddr = gpuf_pkg::TOP_NODE;
                    end
                    default: begin
                        o_map_req.re    = nbr_ok;
                        o_map_req.raddr = gpuf_pkg::site_of(nbr_row, nbr_col);
                    end
                endcase
            end
            gpuf_pkg::S_NBR: begin
                o_par_req.re    = i_map_rdata;
                o_par_req.raddr = r_a;
            end
            gpuf_pkg::S_FIND: begin
                if (!is_root) begin
                    o_par_req.re    = 1'b1;
                    o_par_req.raddr = i_par_rdata;
                end else begin
                    case (r_phase)
                        gpuf_pkg::PH_JOIN_A: begin
                            o_wgt_req.re    = 1'b1;
                            o_wgt_req.raddr = r_cur;
                            o_par_req.re    = 1'b1;
                            o_par_req.raddr = r_b;
                        end
                        gpuf_pkg::PH_JOIN_B: begin
                            o_wgt_req.re    = (r_cur != r_ra);
                            o_wgt_req.raddr = r_cur;
                        end
                        gpuf_pkg::PH_TOP: begin
                            o_par_req.re    = 1'b1;
                            o_par_req.raddr = r_err ? gpuf_pkg::BOTTOM_NODE : r_node;
                        end
                        gpuf_pkg::PH_NODE: begin
                            o_par_req.re    = 1'b1;
                            o_par_req.raddr = gpuf_pkg::BOTTOM_NODE;
                        end
                        default: begin
                            o_par_req.re = 1'b0;
                        end
                    endcase
                end
            end
            gpuf_pkg::S_UNI: begin
                // hang the lighter root below the heavier, ties below the first
                o_par_req.we    = 1'b1;
                o_wgt_req.we    = 1'b1;
                o_wgt_req.wdata = wsum;
                if (r_wa < i_wgt_rdata) begin
                    o_par_req.waddr = r_ra;
                    o_par_req.wdata = r_rb;
                    o_wgt_req.waddr = r_rb;
                end else begin
                    o_par_req.waddr = r_rb;
                    o_par_req.wdata = r_ra;
                    o_wgt_req.waddr = r_ra;
                end
            end
            gpuf_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    assign o_res.was_open       = r_was & ~r_err;
    assign o_res.site_full      = r_full;
    assign o_res.percolates_now = r_perc;
    assign o_res.range_error    = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpuf_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == gpuf_pkg::S_CLEAR) r_clr <= r_clr + gpuf_pkg::NODE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_par_req.re) r_cur <= o_par_req.raddr;
        case (r_state)
            gpuf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_kind  <= i_kind;
                    r_row   <= i_row;
                    r_col   <= i_column;
                    r_err   <= ~in_range;
                    r_node  <= gpuf_pkg::node_of(i_row, i_column);
                    r_phase <= gpuf_pkg::PH_TOP;
                end
            end
            gpuf_pkg::S_SELF: begin
                r_was   <= i_map_rdata;
                r_cand  <= gpuf_pkg::CAND_TOP;
                r_phase <= gpuf_pkg::PH_TOP;
            end
            gpuf_pkg::S_CAND: begin
                case (r_cand)
                    gpuf_pkg::CAND_TOP: begin
                        r_a     <= gpuf_pkg::TOP_NODE;
                        r_b     <= r_node;
                        r_phase <= gpuf_pkg::PH_JOIN_A;
                        r_cand  <= r_cand + gpuf_pkg::CAND_W'(1);
                    end
                    gpuf_pkg::CAND_BOTTOM: begin
                        r_a     <= gpuf_pkg::BOTTOM_NODE;
                        r_b     <= r_node;
                        r_phase <= gpuf_pkg::PH_JOIN_A;
                        r_cand  <= r_cand + gpuf_pkg::CAND_W'(1);
                    end
                    gpuf_pkg::CAND_END: begin
                        r_phase <= gpuf_pkg::PH_TOP;
                    end
                    default: begin
                        r_a    <= r_node;
                        r_b    <= gpuf_pkg::node_of(nbr_row, nbr_col);
                        if (!nbr_ok) r_cand <= r_cand + gpuf_pkg::CAND_W'(1);
                    end
                endcase
            end
            gpuf_pkg::S_NBR: begin
                r_cand  <= r_cand + gpuf_pkg::CAND_W'(1);
                r_phase <= gpuf_pkg::PH_JOIN_A;
            end
            gpuf_pkg::S_FIND: begin
                if (is_root) begin
                    case (r_phase)
                        gpuf_pkg::PH_JOIN_A: begin
                            r_ra    <= r_cur;
                            r_phase <= gpuf_pkg::PH_JOIN_B;
                        end
                        gpuf_pkg::PH_JOIN_B: begin
                            r_rb <= r_cur;
                            r_wa <= i_wgt_rdata;
                        end
                        gpuf_pkg::PH_TOP: begin
                            r_rt    <= r_cur;
                            r_full  <= 1'b0;
                            r_phase <= r_err ? gpuf_pkg::PH_BOTTOM : gpuf_pkg::PH_NODE;
                        end
                        gpuf_pkg::PH_NODE: begin
                            r_full  <= (r_cur == r_rt);
                            r_phase <= gpuf_pkg::PH_BOTTOM;
                        end
                        default: begin
                            r_perc <= (r_cur == r_rt);
                        end
                    endcase
                end
            end
            default: begin
                r_cand <= r_cand;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sim/grid_percolation_union_find_core_test.sv
// ----------------------------------------------------------------------------
// grid_percolation_union_find_core_test
// Self-checking bench for the percolation core: a local union-find model
// predicts each result word; results are matched in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_percolation_union_find_core_test;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [gpuf_pkg::CFG_W-1:0]    i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_kind = 1'b0;
    logic [gpuf_pkg::ROW_W-1:0]    i_row = '0;
    logic [gpuf_pkg::ROW_W-1:0]    i_column = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_was_open;
    logic                          o_site_full;
    logic                          o_percolates_now;
    logic                          o_range_error;

    grid_percolation_union_find_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_row(i_row), .i_column(i_column),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_was_open(o_was_open), .o_site_full(o_site_full),
        .o_percolates_now(o_percolates_now), .o_range_error(o_range_error)
    );

    always #5 i_clk = ~i_clk;

    // Model state: open map, parent links and tree weights at the core's pitch.
    logic [gpuf_pkg::CFG_W-1:0]  side_reg;
    bit                          open_map [gpuf_pkg::SITE_COUNT];
    int unsigned                 parent [gpuf_pkg::NODE_COUNT];
    int unsigned                 weight [gpuf_pkg::NODE_COUNT];

    gpuf_pkg::t_result pending_results [$];
    int                error_count;
    int                words_sent;
    int                words_checked;
    int                full_seen;
    int                perc_seen;
    int                idle_cycles = 0;
    int                send_idle_pct;
    int                recv_stall_pct;

    function automatic int unsigned root_of(int unsigned node);
        int unsigned r;
        int unsigned nxt;
        r = node;
        while (parent[r] != r) r = parent[r];
        while (parent[node] != r) begin
            nxt = parent[node];
            parent[node] = r;
            node = nxt;
        end
        return r;
    endfunction

    function automatic void merge(int unsigned a, int unsigned b);
        int unsigned ra;
        int unsigned rb;
        ra = root_of(a);
        rb = root_of(b);
        if (ra == rb) return;
        if (weight[ra] < weight[rb]) begin
            parent[ra] = rb;
            weight[rb] += weight[ra];
        end else begin
            parent[rb] = ra;
            weight[ra] += weight[rb];
        end
    endfunction

    function automatic void clear_model();
        side_reg = gpuf_pkg::SIDE_RESET;
        for (int k = 0; k < gpuf_pkg::SITE_COUNT; k++) open_map[k] = 1'b0;
        for (int k = 0; k < gpuf_pkg::NODE_COUNT; k++) begin
            parent[k] = k;
            weight[k] = 1;
        end
    endfunction

    // Work out the result word that one input word causes.
    function automatic gpuf_pkg::t_result predict_site(logic kind, int unsigned r,
                                                        int unsigned c);
        gpuf_pkg::t_result res;
        int unsigned side;
        int unsigned s;
        int unsigned nd;
        int unsigned btm;
        btm  = gpuf_pkg::SITE_COUNT + 1;
        side = (side_reg > gpuf_pkg::MAX_SIDE) ? gpuf_pkg::MAX_SIDE : side_reg;
        res  = '0;
        if (r >= side || c >= side) begin
            res.percolates_now = root_of(0) == root_of(btm);
            res.range_error    = 1'b1;
            return res;
        end
        s  = r * gpuf_pkg::MAX_SIDE + c;
        nd = s + 1;
        res.was_open = open_map[s];
        if (kind == gpuf_pkg::KIND_OPEN) begin
            open_map[s] = 1'b1;
            if (r == 0) merge(0, nd);
            if (r == side - 1) merge(btm, nd);
            if (r > 0 && open_map[s - gpuf_pkg::MAX_SIDE])
                merge(nd, nd - gpuf_pkg::MAX_SIDE);
            if (r + 1 < side && open_map[s + gpuf_pkg::MAX_SIDE])
                merge(nd, nd + gpuf_pkg::MAX_SIDE);
            if (c > 0 && open_map[s - 1]) merge(nd, nd - 1);
            if (c + 1 < side && open_map[s + 1]) merge(nd, nd + 1);
        end
        res.site_full      = root_of(0) == root_of(nd);
        res.percolates_now = root_of(0) == root_of(btm);
        return res;
    endfunction

    // Send one word, with random idle before it per the current phase.
    task automatic send_site(logic kind, int unsigned r, int unsigned c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_kind     <= kind;
        i_row      <= gpuf_pkg::ROW_W'(r);
        i_column   <= gpuf_pkg::ROW_W'(c);
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_site(kind, r, c));
        words_sent++;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic pause_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then let the core settle before touching the register.
    task automatic wait_drained();
        pause_drained();
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_side(int unsigned value);
        wait_drained();
        i_cfg_data  <= gpuf_pkg::CFG_W'(value);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        side_reg = gpuf_pkg::CFG_W'(value);
    endtask

    // Result checker; receiver stall is redrawn every cycle.
    always @(posedge i_clk) begin
        gpuf_pkg::t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    words_checked++;
                    if (o_was_open !== want.was_open) begin
                        $error("was_open: expected %0b, got %0b", want.was_open, o_was_open);
                        error_count++;
                    end
                    if (o_site_full !== want.site_full) begin
                        $error("site_full: expected %0b, got %0b", want.site_full, o_site_full);
                        error_count++;
                    end
                    if (o_percolates_now !== want.percolates_now) begin
                        $error("percolates_now: expected %0b, got %0b",
                               want.percolates_now, o_percolates_now);
                        error_count++;
                    end
                    if (o_range_error !== want.range_error) begin
                        $error("range_error: expected %0b, got %0b",
                               want.range_error, o_range_error);
                        error_count++;
                    end
                    full_seen += want.site_full;
                    perc_seen += want.percolates_now;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no accepted word on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("grid_percolation_union_find_core_test: done, errors");
            $finish;
        end
    end

    task automatic test_corners();
        // corners, both kinds; out of range rows and columns at side 32 are impossible
        send_site(gpuf_pkg::KIND_PROBE, 0, 0);
        send_site(gpuf_pkg::KIND_OPEN, 0, 0);
        send_site(gpuf_pkg::KIND_OPEN, 0, 0);
        send_site(gpuf_pkg::KIND_OPEN, 31, 31);
        send_site(gpuf_pkg::KIND_PROBE, 31, 31);
        send_site(gpuf_pkg::KIND_OPEN, 31, 0);
        send_site(gpuf_pkg::KIND_OPEN, 0, 31);
        send_site(gpuf_pkg::KIND_PROBE, 15, 16);
    endtask

    task automatic test_small_sides();
        // side 1: single site is top and bottom, so one open percolates
        write_side(1);
        send_site(gpuf_pkg::KIND_PROBE, 0, 1);
        send_site(gpuf_pkg::KIND_OPEN, 1, 0);
        send_site(gpuf_pkg::KIND_OPEN, 0, 0);
        send_site(gpuf_pkg::KIND_PROBE, 0, 0);
        // side 0: everything out of range
        write_side(0);
        send_site(gpuf_pkg::KIND_OPEN, 0, 0);
        // side above the maximum clamps to 32
        write_side(63);
        send_site(gpuf_pkg::KIND_OPEN, 31, 30);
        send_site(gpuf_pkg::KIND_PROBE, 31, 30);
        // side 3: a column opens top to bottom
        write_side(3);
        send_site(gpuf_pkg::KIND_OPEN, 1, 2);
        send_site(gpuf_pkg::KIND_OPEN, 0, 2);
        send_site(gpuf_pkg::KIND_OPEN, 2, 2);
        send_site(gpuf_pkg::KIND_OPEN, 3, 1);
        send_site(gpuf_pkg::KIND_PROBE, 2, 2);
    endtask

    // Random walk of mostly opens on one side setting; pauses for full drain once.
    task automatic test_random(int unsigned side, int count);
        int unsigned r;
        int unsigned c;
        write_side(side);
        for (int k = 0; k < count; k++) begin
            r = (side > 0 && $urandom_range(9) != 0) ? $urandom_range(side - 1)
                                                     : $urandom_range(31);
            c = (side > 0 && $urandom_range(9) != 0) ? $urandom_range(side - 1)
                                                     : $urandom_range(31);
            send_site(($urandom_range(3) == 0) ? gpuf_pkg::KIND_PROBE : gpuf_pkg::KIND_OPEN,
                      r, c);
            if (k == count / 2) pause_drained();
        end
    endtask

    initial begin
        error_count = 0; words_sent = 0; words_checked = 0;
        full_seen = 0; perc_seen = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        clear_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corners();
        test_small_sides();
        test_random(8, 300);
        send_idle_pct = 81;
        test_random(12, 400);
        send_idle_pct = 0; recv_stall_pct = 81;
        test_random(20, 400);
        send_idle_pct = 7; recv_stall_pct = 7;
        test_random(32, 450);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(5, 300);

        wait_drained();
        $display("covered %0d words, %0d checked: opens, probes, range errors, sides 0..63",
                 words_sent, words_checked);
        $display("full results seen %0d, percolating results seen %0d", full_seen, perc_seen);
        if (error_count == 0)
            $display("grid_percolation_union_find_core_test: done, clean");
        else
            $display("grid_percolation_union_find_core_test: done, errors");
        $finish;
    end

endmodule
